// ===== design/bfta_pkg.sv =====
// shared types and opcodes for the ticket allocator
`default_nettype none
package bfta_pkg;
	localparam int unsigned PRICE_W = 31;
	localparam int unsigned OP_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic scan_start;
		logic scan_step;
		logic mark;
	} bfta_cmd_t;

	typedef struct packed {
		logic full;
		logic scan_last;
	} bfta_sts_t;
endpackage
`default_nettype wire

// ===== design/bfta_if.sv =====
// valid/ready channel interfaces for items and results
`default_nettype none
interface bfta_in_if;
	import bfta_pkg::*;
	logic valid;
	logic ready;
	logic [OP_W-1:0] opcode;
	logic [PRICE_W-1:0] value;
	modport source (output valid, opcode, value, input ready);
	modport sink (input valid, opcode, value, output ready);
endinterface

interface bfta_out_if;
	import bfta_pkg::*;
	logic valid;
	logic ready;
	logic found;
	logic [PRICE_W-1:0] price;
	modport source (output valid, found, price, input ready);
	modport sink (input valid, found, price, output ready);
endinterface
`default_nettype wire

// ===== design/bfta_datapath.sv =====
// ticket memory, sold marks, count and linear best-fit scan
`default_nettype none
module bfta_datapath
	import bfta_pkg::*;
#(
	parameter int unsigned MAX_TICKETS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bfta_cmd_t          cmd,
	input  wire logic [PRICE_W-1:0] value,
	output bfta_sts_t               sts,
	output logic                    found,
	output logic [PRICE_W-1:0]      price
);
	localparam int unsigned IDX_W = $clog2(MAX_TICKETS);
	localparam int unsigned CNT_W = $clog2(MAX_TICKETS + 1);

	logic [PRICE_W-1:0] mem [MAX_TICKETS];
	// sold mark of each slot, rewritten by every load that is stored, so no clearing is needed
	logic sold_mem [MAX_TICKETS];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic [PRICE_W-1:0] max_q;
	logic [PRICE_W-1:0] rd_q;
	logic sold_rd_q;
	logic rd_ok_q;
	logic have_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [PRICE_W-1:0] best_q;
	logic [IDX_W-1:0] rd_idx_q;

	assign sts.full = (count_q == CNT_W'(MAX_TICKETS));
	// last step: read address past the fill and last read already evaluated
	assign sts.scan_last = (scan_q >= count_q) && !rd_ok_q;
	assign found = have_q;
	assign price = have_q ? best_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.load && !sts.full) begin
			mem[count_q[IDX_W-1:0]] <= value;
			sold_mem[count_q[IDX_W-1:0]] <= 1'b0;
		end else if (cmd.mark && have_q) begin
			sold_mem[best_idx_q] <= 1'b1;
		end
		rd_q <= mem[scan_q[IDX_W-1:0]];
		sold_rd_q <= sold_mem[scan_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			scan_q <= '0;
			rd_ok_q <= 1'b0;
			have_q <= 1'b0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.load) begin
			if (!sts.full) begin
				count_q <= count_q + 1'b1;
			end
		end else if (cmd.scan_start) begin
			scan_q <= '0;
			rd_ok_q <= 1'b0;
			have_q <= 1'b0;
			max_q <= value;
		end else if (cmd.scan_step) begin
			// one entry read per cycle, evaluated the cycle after
			rd_ok_q <= (scan_q < count_q);
			rd_idx_q <= scan_q[IDX_W-1:0];
			if (scan_q < count_q) begin
				scan_q <= scan_q + 1'b1;
			end
			if (rd_ok_q && !sold_rd_q && rd_q <= max_q &&
					(!have_q || rd_q > best_q)) begin
				have_q <= 1'b1;
				best_q <= rd_q;
				best_idx_q <= rd_idx_q;
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/bfta_ctrl.sv =====
// sequencer for load, clear and query items
`default_nettype none
module bfta_ctrl
	import bfta_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	bfta_in_if.sink       in_ch,
	input  wire logic     out_ready,
	output logic          out_valid,
	output bfta_cmd_t     cmd,
	input  wire bfta_sts_t sts
);
	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MARK, S_OUT} state_t;
	state_t state_q;
	logic take;

	assign in_ch.ready = (state_q == S_IDLE);
	assign take = in_ch.valid && in_ch.ready;
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.load = take && (op_t'(in_ch.opcode) == OP_LOAD);
		cmd.clear = take && (op_t'(in_ch.opcode) == OP_CLEAR);
		cmd.scan_start = take && (op_t'(in_ch.opcode) == OP_QUERY);
		cmd.scan_step = (state_q == S_SCAN);
		cmd.mark = (state_q == S_MARK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (cmd.scan_start) state_q <= S_SCAN;
				S_SCAN: if (sts.scan_last) state_q <= S_MARK;
				S_MARK: state_q <= S_OUT;
				S_OUT:  if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/best_fit_ticket_allocator_unit.sv =====
// best-fit ticket allocator: control and datapath
// load and clear act on the transfer; a query scans every filled slot,
// one memory read per cycle, and then marks the best-fitting ticket sold
// one item at a time; the result sits in the output until transferred
// asynchronous reset empties the store; no clearing pass is needed
`default_nettype none
module best_fit_ticket_allocator_unit
	import bfta_pkg::*;
#(
	parameter int unsigned MAX_TICKETS = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bfta_in_if.sink   in_ch,
	bfta_out_if.source out_ch
);
	bfta_cmd_t cmd;
	bfta_sts_t sts;

	bfta_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ready(out_ch.ready),
		.out_valid(out_ch.valid), .cmd(cmd), .sts(sts)
	);

	bfta_datapath #(.MAX_TICKETS(MAX_TICKETS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .value(in_ch.value), .sts(sts),
		.found(out_ch.found), .price(out_ch.price)
	);
endmodule
`default_nettype wire
